[rtl/pbb_pkg.sv]
`timescale 1ns / 1ps

package pbb_pkg;

	localparam int PIX_W      = 16;
	localparam int SUM_W      = 24;
	localparam int BLK_REG_W  = 5;
	localparam int IMG_REG_W  = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = 12;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EIGHT_BIT_MODE = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PAD_W,
		ST_PAD_H,
		ST_READ,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

[rtl/pbb_mem.sv]
`timescale 1ns / 1ps

module pbb_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/pbb_div.sv]
`timescale 1ns / 1ps

module pbb_div #(
	parameter int DW = 25,
	parameter int VW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    num_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    div_q;
	logic [VW:0]      shifted;
	logic [VW:0]      diff;
	logic             ge;

	// One quotient bit per cycle, most significant first (restoring division).
	always_comb begin
		shifted = {rem_q, num_q[DW-1]};
		diff    = shifted - {1'b0, div_q};
		ge      = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

[rtl/pixel_block_binning.sv]
`timescale 1ns / 1ps
// A pixel that completes no block passes through accept, line store read, and accumulate
// and write back; the next request is taken only once the block is idle again.
// A pixel that completes a block adds the serial divider: its result is registered once the
// division is done and the output is free, and the next request is taken after that.
// After reset every one of the MAX_WIDTH line store entries is cleared, then the edge padding
// is derived from the registers by the divider (repeated after any register write).
module pixel_block_binning
	import pbb_pkg::*;
#(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_BLOCK = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     binned_pixel,
	output logic                 end_of_row,
	output logic                 end_of_frame
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int BW_W   = $clog2(MAX_BLOCK + 1);
	localparam int KB_W   = $clog2(MAX_BLOCK);
	localparam int AREA_W = 2 * BW_W;
	localparam int PROD_W = PIX_W + AREA_W;
	localparam int DIV_A  = (SUM_W + 1 > WW) ? SUM_W + 1 : WW;
	localparam int DIV_DW = (DIV_A > HW) ? DIV_A : HW;

	// Configuration registers.
	logic [BLK_REG_W-1:0] block_width_q;
	logic [BLK_REG_W-1:0] block_height_q;
	logic [IMG_REG_W-1:0] image_width_q;
	logic [IMG_REG_W-1:0] image_height_q;
	logic                 eight_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_width_q  <= BLK_REG_W'(2);
			block_height_q <= BLK_REG_W'(2);
			image_width_q  <= IMG_REG_W'(4096);
			image_height_q <= IMG_REG_W'(4096);
			eight_bit_q    <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BLOCK_WIDTH:    block_width_q  <= cfg_data[BLK_REG_W-1:0];
				REG_BLOCK_HEIGHT:   block_height_q <= cfg_data[BLK_REG_W-1:0];
				REG_IMAGE_WIDTH:    image_width_q  <= cfg_data[IMG_REG_W-1:0];
				REG_IMAGE_HEIGHT:   image_height_q <= cfg_data[IMG_REG_W-1:0];
				REG_EIGHT_BIT_MODE: eight_bit_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective sizes: zero counts as one, oversize values are limited.
	logic [BW_W-1:0] bw_c;
	logic [BW_W-1:0] bh_c;
	logic [WW-1:0]   w_c;
	logic [HW-1:0]   h_c;

	always_comb begin
		if (block_width_q == '0) begin
			bw_c = BW_W'(1);
		end else if (32'(block_width_q) > 32'(MAX_BLOCK)) begin
			bw_c = BW_W'(MAX_BLOCK);
		end else begin
			bw_c = BW_W'(block_width_q);
		end
		if (block_height_q == '0) begin
			bh_c = BW_W'(1);
		end else if (32'(block_height_q) > 32'(MAX_BLOCK)) begin
			bh_c = BW_W'(MAX_BLOCK);
		end else begin
			bh_c = BW_W'(block_height_q);
		end
		if (image_width_q == '0) begin
			w_c = WW'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_c = HW'(1);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(image_height_q);
		end
	end

	// Position counters and control.
	state_t            st_q;
	state_t            st_nxt;
	logic              dirty_q;
	logic              dirty_clr;
	logic [CW-1:0]     clr_cnt_q;
	logic [CW-1:0]     col_pos_q;
	logic [ROW_W-1:0]  row_pos_q;
	logic [KB_W-1:0]   cib_q;
	logic [KB_W-1:0]   rib_q;
	logic [CW-1:0]     bci_q;
	logic [BW_W-1:0]   pad_w_q;
	logic [BW_W-1:0]   pad_h_q;

	logic              in_acc;
	logic              last_col;
	logic              last_row;
	logic              blk_col_end;
	logic              blk_row_end;
	logic [BW_W-1:0]   wx;
	logic [BW_W-1:0]   wy;
	logic [PIX_W-1:0]  pix_in;

	assign in_stall = !(st_q == ST_IDLE && !dirty_q);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		last_col    = 32'(col_pos_q) >= 32'(w_c) - 32'd1;
		last_row    = 32'(row_pos_q) >= 32'(h_c) - 32'd1;
		blk_col_end = last_col || (32'(cib_q) >= 32'(bw_c) - 32'd1);
		blk_row_end = last_row || (32'(rib_q) >= 32'(bh_c) - 32'd1);
		wx          = BW_W'(1) + (last_col ? pad_w_q : '0);
		wy          = BW_W'(1) + (last_row ? pad_h_q : '0);
		// Scaling by 257 replicates the byte into both halves.
		pix_in      = eight_bit_q ? {pixel[7:0], pixel[7:0]} : pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			row_pos_q <= '0;
			cib_q     <= '0;
			rib_q     <= '0;
			bci_q     <= '0;
		end else if (in_acc) begin
			if (blk_col_end) begin
				cib_q <= '0;
				bci_q <= (32'(bci_q) == MAX_WIDTH - 1) ? '0 : bci_q + 1'b1;
			end else begin
				cib_q <= cib_q + 1'b1;
			end
			if (last_col) begin
				col_pos_q <= '0;
				cib_q     <= '0;
				bci_q     <= '0;
				if (last_row) begin
					row_pos_q <= '0;
					rib_q     <= '0;
				end else begin
					row_pos_q <= row_pos_q + 1'b1;
					rib_q     <= blk_row_end ? '0 : rib_q + 1'b1;
				end
			end else begin
				col_pos_q <= col_pos_q + 1'b1;
			end
		end
	end

	// Request in flight.
	logic [CW-1:0]     idx_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [AREA_W-1:0] weight_s1;
	logic              emit_s1;
	logic              eor_s1;
	logic              eof_s1;
	logic [SUM_W-1:0]  prod_s2;
	logic [PROD_W-1:0] prod_full;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1    <= bci_q;
			pix_s1    <= pix_in;
			weight_s1 <= AREA_W'(wx) * AREA_W'(wy);
			emit_s1   <= blk_col_end && blk_row_end;
			eor_s1    <= last_col;
			eof_s1    <= last_col && last_row;
		end
		if (st_q == ST_READ) begin
			prod_s2 <= SUM_W'(prod_full);
		end
	end

	assign prod_full = PROD_W'(pix_s1) * PROD_W'(weight_s1);

	// Line store of block column sums.
	logic              mem_we;
	logic [CW-1:0]     mem_waddr;
	logic [SUM_W-1:0]  mem_wdata;
	logic [SUM_W-1:0]  mem_rdata;

	pbb_mem #(
		.DEPTH(MAX_WIDTH),
		.AW   (CW),
		.DW   (SUM_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (in_acc),
		.raddr(bci_q),
		.rdata(mem_rdata)
	);

	// Shared divider: edge padding after reset and register writes, block means otherwise.
	logic              div_start;
	logic [DIV_DW-1:0] div_a;
	logic [AREA_W-1:0] div_b;
	logic              div_done;
	logic [DIV_DW-1:0] div_quo;
	logic [AREA_W-1:0] div_rem;

	pbb_div #(
		.DW(DIV_DW),
		.VW(AREA_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	logic [SUM_W-1:0]  sum_acc;
	logic [AREA_W-1:0] area;
	logic [BW_W-1:0]   pad_w_new;
	logic [BW_W-1:0]   pad_h_new;
	logic [PIX_W-1:0]  mean;
	logic              pad_w_ld;
	logic              pad_h_ld;
	logic              out_load;
	logic              out_valid_q;
	logic [PIX_W-1:0]  binned_q;
	logic              eor_q;
	logic              eof_q;

	always_comb begin
		sum_acc   = mem_rdata + prod_s2;
		area      = AREA_W'(bw_c) * AREA_W'(bh_c);
		pad_w_new = (div_rem == '0) ? '0 : bw_c - BW_W'(div_rem);
		pad_h_new = (div_rem == '0) ? '0 : bh_c - BW_W'(div_rem);
		mean      = (|div_quo[DIV_DW-1:PIX_W]) ? '1 : div_quo[PIX_W-1:0];
	end

	always_comb begin
		st_nxt    = st_q;
		div_start = 1'b0;
		div_a     = '0;
		div_b     = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		dirty_clr = 1'b0;
		pad_w_ld  = 1'b0;
		pad_h_ld  = 1'b0;
		out_load  = 1'b0;
		unique case (st_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				if (32'(clr_cnt_q) == MAX_WIDTH - 1) begin
					st_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (dirty_q) begin
					div_start = 1'b1;
					div_a     = DIV_DW'(w_c);
					div_b     = AREA_W'(bw_c);
					dirty_clr = 1'b1;
					st_nxt    = ST_PAD_W;
				end else if (in_valid) begin
					st_nxt = ST_READ;
				end
			end
			ST_PAD_W: begin
				if (div_done) begin
					pad_w_ld  = 1'b1;
					div_start = 1'b1;
					div_a     = DIV_DW'(h_c);
					div_b     = AREA_W'(bh_c);
					st_nxt    = ST_PAD_H;
				end
			end
			ST_PAD_H: begin
				if (div_done) begin
					pad_h_ld = 1'b1;
					st_nxt   = ST_IDLE;
				end
			end
			ST_READ: begin
				st_nxt = ST_ACC;
			end
			ST_ACC: begin
				mem_we    = 1'b1;
				mem_waddr = idx_s1;
				if (emit_s1) begin
					// Half the area is added first so that the quotient rounds half up.
					div_start = 1'b1;
					div_a     = DIV_DW'(sum_acc) + DIV_DW'(area >> 1);
					div_b     = area;
					st_nxt    = ST_DIV;
				end else begin
					mem_wdata = sum_acc;
					st_nxt    = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					st_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					st_nxt   = ST_IDLE;
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			dirty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			// A write during the padding calculation forces it to run again.
			if (cfg_write) begin
				dirty_q <= 1'b1;
			end else if (dirty_clr) begin
				dirty_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pad_w_ld) begin
			pad_w_q <= pad_w_new;
		end
		if (pad_h_ld) begin
			pad_h_q <= pad_h_new;
		end
		if (out_load) begin
			binned_q <= mean;
			eor_q    <= eor_s1;
			eof_q    <= eof_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign binned_pixel = binned_q;
	assign end_of_row   = eor_q;
	assign end_of_frame = eof_q;

endmodule

[test/tb_pixel_block_binning.sv]
`timescale 1ns / 1ps

module tb_pixel_block_binning
	import pbb_pkg::*;
();

	localparam int LINE_DEPTH  = 4096;
	localparam int BLOCK_LIMIT = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 40;
	localparam int ITEM_TARGET = 1950;

	typedef struct {
		logic [PIX_W-1:0] value;
		bit               eor;
		bit               eof;
	} binned_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [PIX_W-1:0]      binned_pixel;
	logic                  end_of_row;
	logic                  end_of_frame;

	pixel_block_binning u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.binned_pixel (binned_pixel),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

	// Register copies, as written.
	int unsigned reg_bw    = 2;
	int unsigned reg_bh    = 2;
	int unsigned reg_w     = 4096;
	int unsigned reg_h     = 4096;
	int unsigned reg_eight = 0;

	// Line store and raster position of the predictor.
	logic [SUM_W-1:0] line_sums [LINE_DEPTH];
	int unsigned col_pos, row_pos, col_in_blk, row_in_blk, blk_col;

	logic [PIX_W-1:0] pending_pixels [$];
	binned_t          expected_bins [$];
	binned_t          oldest_bin;

	int errors        = 0;
	int items_sent    = 0;
	int cycles        = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic int unsigned edge_pad(int unsigned size, int unsigned blk);
		return (blk - (size % blk)) % blk;
	endfunction

	function automatic bit at_frame_start();
		return col_pos == 0 && row_pos == 0 && col_in_blk == 0 && row_in_blk == 0
			&& blk_col == 0;
	endfunction

	function automatic logic [PIX_W-1:0] any_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(65535));
		endcase
	endfunction

	// Adds one pixel to its block column and queues the block mean when the block closes.
	task automatic bin_pixel(input logic [PIX_W-1:0] px);
		int unsigned bw, bh, w, h, p, wx, wy, idx, area, mean, acc;
		bit last_col, last_row, col_end, row_end;
		binned_t r;
		bw = clamp_size(reg_bw, BLOCK_LIMIT);
		bh = clamp_size(reg_bh, BLOCK_LIMIT);
		w = clamp_size(reg_w, LINE_DEPTH);
		h = clamp_size(reg_h, MAX_HEIGHT);
		p = px;
		last_col = col_pos >= w - 1;
		last_row = row_pos >= h - 1;
		col_end = last_col || col_in_blk >= bw - 1;
		row_end = last_row || row_in_blk >= bh - 1;
		wx = 1 + (last_col ? edge_pad(w, bw) : 0);
		wy = 1 + (last_row ? edge_pad(h, bh) : 0);
		idx = blk_col;
		if (reg_eight != 0)
			p = (p & 32'hFF) * 257;
		if (idx >= LINE_DEPTH)
			idx = 0;
		acc = (line_sums[idx] + p * wx * wy) & 32'hFF_FFFF;
		line_sums[idx] = acc[SUM_W-1:0];
		if (col_end && row_end) begin
			area = bw * bh;
			mean = (acc + area / 2) / area;
			if (mean > 65535)
				mean = 65535;
			r.value = mean[PIX_W-1:0];
			r.eor = last_col;
			r.eof = last_col && last_row;
			expected_bins.push_back(r);
			line_sums[idx] = '0;
		end
		if (col_end) begin
			col_in_blk = 0;
			blk_col = idx + 1;
			if (blk_col >= LINE_DEPTH)
				blk_col = 0;
		end else begin
			col_in_blk++;
		end
		if (last_col) begin
			col_pos = 0;
			col_in_blk = 0;
			blk_col = 0;
			if (last_row) begin
				row_pos = 0;
				row_in_blk = 0;
			end else begin
				row_pos++;
				row_in_blk = row_end ? 0 : row_in_blk + 1;
			end
		end else begin
			col_pos++;
		end
	endtask

	// Pixel driver: a new request is offered once the previous one has been taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				bin_pixel(pixel);
			if (!in_valid || !in_stall) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					pixel <= pending_pixels.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_bins.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %h eor %b eof %b",
						$time, binned_pixel, end_of_row, end_of_frame);
				end else begin
					oldest_bin = expected_bins.pop_front();
					if (binned_pixel !== oldest_bin.value) begin
						errors++;
						$display("%0t: binned_pixel expected %h, got %h",
							$time, oldest_bin.value, binned_pixel);
					end
					if (end_of_row !== oldest_bin.eor) begin
						errors++;
						$display("%0t: end_of_row expected %b, got %b",
							$time, oldest_bin.eor, end_of_row);
					end
					if (end_of_frame !== oldest_bin.eof) begin
						errors++;
						$display("%0t: end_of_frame expected %b, got %b",
							$time, oldest_bin.eof, end_of_frame);
					end
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic push_pixel(input logic [PIX_W-1:0] px);
		pending_pixels.push_back(px);
		items_sent++;
	endtask

	// Holds the sender back until every request has gone through and all results are in.
	// The queues and the valid are looked at on the falling edge, when they are settled.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_bins.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
	endtask

	task automatic set_geometry(input int unsigned bw, bh, w, h, eight);
		wait_idle();
		if (items_sent < ITEM_TARGET / 3) begin
			send_idle_pct = 36;
			recv_idle_pct = 69;
		end else if (items_sent < 2 * ITEM_TARGET / 3) begin
			send_idle_pct = 69;
			recv_idle_pct = 36;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		write_reg(REG_BLOCK_WIDTH, bw);
		write_reg(REG_BLOCK_HEIGHT, bh);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_EIGHT_BIT_MODE, eight);
		@(posedge clk);
		cfg_write <= 1'b0;
		reg_bw = bw & 32'h1F;
		reg_bh = bh & 32'h1F;
		reg_w = w & 32'h1FFF;
		reg_h = h & 32'h1FFF;
		reg_eight = eight & 1;
	endtask

	// A one-pixel image closes whatever frame is open and returns every counter to zero.
	task automatic close_frame();
		set_geometry(reg_bw, reg_bh, 1, 1, reg_eight);
		push_pixel(any_pixel());
	endtask

	initial begin : stimulus
		int unsigned bw, bh, w, h, frames, span;
		foreach (line_sums[i])
			line_sums[i] = '0;
		col_pos = 0;
		row_pos = 0;
		col_in_blk = 0;
		row_in_blk = 0;
		blk_col = 0;
		send_idle_pct = 36;
		recv_idle_pct = 69;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: a few pixels into a large frame, no block closes.
		push_pixel(16'hFFFF);
		push_pixel(16'h0000);
		push_pixel(16'h8001);
		push_pixel(16'h7FFE);
		// Zero image size counts as one, so the open frame closes on the next pixel.
		set_geometry(2, 2, 0, 0, 0);
		push_pixel(16'hFFFF);
		// Oversized block width, zero block height, eight-bit mode, wide right padding.
		set_geometry(31, 0, 3, 1, 1);
		push_pixel(16'hFF00);
		push_pixel(16'h00FF);
		push_pixel(16'hABCD);
		// Shrinking the block mid-frame leaves a full row in one accumulator: mean saturates.
		set_geometry(4, 2, 4, 4, 0);
		repeat (4) push_pixel(16'hFFFF);
		set_geometry(1, 1, 4, 4, 0);
		push_pixel(16'hFFFF);
		close_frame();
		// Bottom and corner padding.
		set_geometry(2, 3, 3, 2, 0);
		push_pixel(16'hFFFF);
		push_pixel(16'h0001);
		push_pixel(16'h8000);
		push_pixel(16'h7FFF);
		push_pixel(16'hFFFE);
		push_pixel(16'h0000);
		// Oversized image clamps to the largest frame; the next phase cuts it short.
		set_geometry(16, 16, 8191, 8191, 0);
		repeat (8) push_pixel(any_pixel());

		while (items_sent < ITEM_TARGET) begin
			if (!at_frame_start() && $urandom_range(1) == 1)
				close_frame();
			bw = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
			bh = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
			if ($urandom_range(15) == 0) begin
				w = $urandom_range(100, 300);
				h = 1;
			end else begin
				w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 48);
				h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
			end
			set_geometry(bw, bh, w, h, $urandom_range(1));
			span = clamp_size(w, LINE_DEPTH) * clamp_size(h, MAX_HEIGHT);
			frames = (span <= 120) ? $urandom_range(1, 3) : 1;
			repeat (frames * span) push_pixel(any_pixel());
			// Now and then a frame is left unfinished.
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(1, span)) push_pixel(any_pixel());
		end

		wait_idle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[pixel_block_binning.f]
rtl/pbb_pkg.sv
rtl/pbb_mem.sv
rtl/pbb_div.sv
rtl/pixel_block_binning.sv
test/tb_pixel_block_binning.sv
